### hw/rtl/generational_handle_allocator_unit_macros.svh
// assertion macros for the generational handle allocator checker
// no dependencies; included by the checker file only
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GHAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ghau: same-cycle check failed");

// next-cycle implication, disabled during reset
`define GHAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ghau: next-cycle check failed");

`endif

### hw/rtl/ghau_pkg.sv
// shared types and constants of the generational handle allocator
// no dependencies; used by the interfaces, the store, the control and the checker
package ghau_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int GEN_W    = 16;
	localparam int CNT_W    = IDX_W + 1;

	localparam logic [1:0] KIND_CREATE  = 2'd0;
	localparam logic [1:0] KIND_DESTROY = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DEAD = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [GEN_W-1:0] gen_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic valid;
		gen_t gen;
	} gen_entry_t;

	typedef struct packed {
		idx_t idx;
		gen_t gen;
	} free_entry_t;

	typedef struct packed {
		logic en;
		idx_t gen_addr;
		idx_t slot_addr;
		idx_t live_addr;
		idx_t free_addr;
	} mem_rd_t;

	typedef struct packed {
		gen_entry_t  gen;
		idx_t        slot;
		idx_t        live;
		free_entry_t free;
	} mem_rdata_t;

	typedef struct packed {
		logic        gen_we;
		idx_t        gen_addr;
		gen_entry_t  gen_data;
		logic        slot_we;
		idx_t        slot_addr;
		idx_t        slot_data;
		logic        live_we;
		idx_t        live_addr;
		idx_t        live_data;
		logic        free_we;
		idx_t        free_addr;
		free_entry_t free_data;
	} mem_wr_t;

endpackage

### hw/rtl/ghau_if.sv
// request and response channel interfaces of the handle allocator
// depends on ghau_pkg
interface ghau_req_if import ghau_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	idx_t       handle_index;
	gen_t       handle_generation;

	modport source (output valid, kind, handle_index, handle_generation, input ready);
	modport sink (input valid, kind, handle_index, handle_generation, output ready);
endinterface

interface ghau_rsp_if import ghau_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] status;
	idx_t       new_index;
	gen_t       new_generation;
	logic       alive;
	idx_t       live_count;

	modport source (output valid, status, new_index, new_generation, alive, live_count,
		input ready);
	modport sink (input valid, status, new_index, new_generation, alive, live_count,
		output ready);
endinterface

### hw/rtl/ghau_store.sv
// state memories: generation table, slot of index, live list, free stack
// depends on ghau_pkg; synchronous memories, one write and one read port each, registered read data
module ghau_store import ghau_pkg::*; (
	input  logic       clk,
	input  mem_rd_t    rd,
	input  mem_wr_t    wr,
	output mem_rdata_t rdata
);

	gen_entry_t  gen_mem  [CAPACITY];
	idx_t        slot_mem [CAPACITY];
	idx_t        live_mem [CAPACITY];
	free_entry_t free_mem [CAPACITY];

	// valid flag lives next to the generation, written on first use
	// freed entries keep the bumped generation so reuse needs no table read
	always_ff @(posedge clk) begin
		if (wr.gen_we)
			gen_mem[wr.gen_addr] <= wr.gen_data;
		if (wr.slot_we)
			slot_mem[wr.slot_addr] <= wr.slot_data;
		if (wr.live_we)
			live_mem[wr.live_addr] <= wr.live_data;
		if (wr.free_we)
			free_mem[wr.free_addr] <= wr.free_data;
		if (rd.en) begin
			rdata.gen  <= gen_mem[rd.gen_addr];
			rdata.slot <= slot_mem[rd.slot_addr];
			rdata.live <= live_mem[rd.live_addr];
			rdata.free <= free_mem[rd.free_addr];
		end
	end

endmodule

### hw/rtl/ghau_ctrl.sv
// control of the handle allocator: read issue, check, write-back, counters
// depends on ghau_pkg and ghau_if; drives the memories in ghau_store
module ghau_ctrl import ghau_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	ghau_req_if.sink        req,
	ghau_rsp_if.source      rsp,
	output mem_rd_t         rd,
	output mem_wr_t         wr,
	input  mem_rdata_t      rdata
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t     state_q;
	cnt_t       free_top_q;
	cnt_t       next_fresh_q;
	cnt_t       live_total_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	idx_t       new_index_q;
	gen_t       new_gen_q;
	logic       alive_q;
	idx_t       live_count_q;

	logic [1:0] kind_s1;
	idx_t       idx_s1;
	gen_t       gen_s1;

	logic       accept;
	logic       fire;
	logic       hit;
	cnt_t       live_dec;
	cnt_t       free_dec;
	idx_t       last_slot;
	gen_t       gen_inc;

	logic [1:0] st;
	idx_t       got;
	gen_t       got_gen;
	logic       n_alive;
	idx_t       n_idx;
	gen_t       n_gen;
	cnt_t       nxt_free_top;
	cnt_t       nxt_fresh;
	cnt_t       nxt_live;
	mem_wr_t    wr_raw;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign fire      = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	assign live_dec  = live_total_q - cnt_t'(1);
	assign free_dec  = free_top_q - cnt_t'(1);
	assign last_slot = live_dec[IDX_W-1:0];
	assign gen_inc   = gen_s1 + gen_t'(1);

	// reads go out at the accepting edge, data is back for the execute cycle
	always_comb begin
		rd.en        = accept;
		rd.gen_addr  = req.handle_index;
		rd.slot_addr = req.handle_index;
		rd.live_addr = last_slot;
		rd.free_addr = free_dec[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			idx_s1  <= req.handle_index;
			gen_s1  <= req.handle_generation;
		end
	end

	// entries at or above the fresh mark were never written, so range check goes first
	assign hit = (idx_s1 != '0) && (cnt_t'(idx_s1) < next_fresh_q)
		&& rdata.gen.valid && (rdata.gen.gen == gen_s1);

	always_comb begin
		wr_raw       = '0;
		st           = ST_OK;
		got          = '0;
		got_gen      = '0;
		n_alive      = 1'b0;
		n_idx        = '0;
		n_gen        = '0;
		nxt_free_top = free_top_q;
		nxt_fresh    = next_fresh_q;
		nxt_live     = live_total_q;
		unique case (kind_s1)
			KIND_CREATE: begin
				if (free_top_q != '0) begin
					got          = rdata.free.idx;
					got_gen      = rdata.free.gen;
					nxt_free_top = free_dec;
				end else if (next_fresh_q < cnt_t'(CAPACITY)) begin
					got       = next_fresh_q[IDX_W-1:0];
					got_gen   = gen_t'(1);
					nxt_fresh = next_fresh_q + cnt_t'(1);
				end else begin
					st = ST_FULL;
				end
				if (st == ST_OK) begin
					wr_raw.gen_we    = 1'b1;
					wr_raw.gen_addr  = got;
					wr_raw.gen_data  = '{valid: 1'b1, gen: got_gen};
					wr_raw.live_we   = 1'b1;
					wr_raw.live_addr = live_total_q[IDX_W-1:0];
					wr_raw.live_data = got;
					wr_raw.slot_we   = 1'b1;
					wr_raw.slot_addr = got;
					wr_raw.slot_data = live_total_q[IDX_W-1:0];
					nxt_live         = live_total_q + cnt_t'(1);
					n_idx            = got;
					n_gen            = got_gen;
				end
			end
			KIND_DESTROY: begin
				if (hit) begin
					n_alive = 1'b1;
					// move the last live entry into the hole
					if (rdata.slot != last_slot) begin
						wr_raw.live_we   = 1'b1;
						wr_raw.live_addr = rdata.slot;
						wr_raw.live_data = rdata.live;
						wr_raw.slot_we   = 1'b1;
						wr_raw.slot_addr = rdata.live;
						wr_raw.slot_data = rdata.slot;
					end
					wr_raw.gen_we    = 1'b1;
					wr_raw.gen_addr  = idx_s1;
					wr_raw.gen_data  = '{valid: 1'b0, gen: gen_inc};
					wr_raw.free_we   = 1'b1;
					wr_raw.free_addr = free_top_q[IDX_W-1:0];
					wr_raw.free_data = '{idx: idx_s1, gen: gen_inc};
					nxt_live         = live_dec;
					nxt_free_top     = free_top_q + cnt_t'(1);
				end else begin
					st = ST_DEAD;
				end
			end
			default: begin
				if (hit)
					n_alive = 1'b1;
				else
					st = ST_DEAD;
			end
		endcase
	end

	always_comb begin
		wr         = wr_raw;
		wr.gen_we  = wr_raw.gen_we && fire;
		wr.slot_we = wr_raw.slot_we && fire;
		wr.live_we = wr_raw.live_we && fire;
		wr.free_we = wr_raw.free_we && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_top_q   <= '0;
			next_fresh_q <= cnt_t'(1);
			live_total_q <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			new_index_q  <= '0;
			new_gen_q    <= '0;
			alive_q      <= 1'b0;
			live_count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				free_top_q   <= nxt_free_top;
				next_fresh_q <= nxt_fresh;
				live_total_q <= nxt_live;
				out_valid_q  <= 1'b1;
				status_q     <= st;
				new_index_q  <= n_idx;
				new_gen_q    <= n_gen;
				alive_q      <= n_alive;
				live_count_q <= nxt_live[IDX_W-1:0];
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.new_index      = new_index_q;
	assign rsp.new_generation = new_gen_q;
	assign rsp.alive          = alive_q;
	assign rsp.live_count     = live_count_q;

endmodule

### hw/rtl/generational_handle_allocator_unit.sv
// Generational handle allocator: creates, destroys and checks handles made of
// an entity index and a generation. Index 0 is the null handle.
// Channels: req (kind, handle_index, handle_generation) and rsp (status,
// new_index, new_generation, alive, live_count), both valid/ready; a
// transaction completes on a clock edge with valid and ready high.
// Each request gives exactly one response, in order.
// The request is registered and the state memories are read as it is taken;
// the execute state loads the response into the output register when rsp is free.
// One operation in flight: no new request is taken until the execute state
// has fired; the idle state reads the state memories, the execute state checks,
// writes back and loads the output register.
// A waiting response does not block the next request from being taken; the
// block holds in its write-back cycle only while rsp is stalled and full.
// Reset (arst_n low) empties the allocator: no live handles, no freed indices,
// next fresh index 1. The memories need no clearing pass, the block is ready
// as soon as reset is released.
// Depends on ghau_pkg, ghau_if, ghau_store and ghau_ctrl.
module generational_handle_allocator_unit import ghau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ghau_req_if.sink    req,
	ghau_rsp_if.source  rsp
);

	mem_rd_t    rd;
	mem_wr_t    wr;
	mem_rdata_t rdata;

	ghau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	ghau_store u_store (
		.clk   (clk),
		.rd    (rd),
		.wr    (wr),
		.rdata (rdata)
	);

endmodule

### hw/rtl/ghau_checker.sv
// port-level checks of the handle allocator, bound to the top level
// depends on ghau_pkg and generational_handle_allocator_unit_macros.svh
`include "generational_handle_allocator_unit_macros.svh"

module ghau_checker import ghau_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input idx_t       rsp_new_index,
	input gen_t       rsp_new_generation,
	input logic       rsp_alive
);

	// a stalled response stays up
	`GHAU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	// one operation at a time: no request taken right after a transaction
	`GHAU_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)
	// full create leaves no handle behind
	`GHAU_ASSERT_IMPLY(a_full_empty, clk, arst_n, rsp_valid && (rsp_status == ST_FULL), (rsp_new_index == '0) && (rsp_new_generation == '0) && !rsp_alive)
	// alive only comes from a destroy or query that succeeded
	`GHAU_ASSERT_IMPLY(a_alive_ok, clk, arst_n, rsp_valid && rsp_alive, (rsp_status == ST_OK) && (rsp_new_index == '0))

endmodule

bind generational_handle_allocator_unit ghau_checker u_ghau_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_new_index      (rsp.new_index),
	.rsp_new_generation (rsp.new_generation),
	.rsp_alive          (rsp.alive)
);
